// ===== src/rsgf_pkg.sv =====
// shared types, widths and fixed-point colour coefficients for the region sepia/gray filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rsgf_pkg;

   localparam int MAX_DIM        = 4096;
   localparam int COEF_FRAC_BITS = 10;

   localparam int CHAN_W      = 8;
   localparam int COORD_W     = 12;
   localparam int COUNT_W     = 13;
   localparam int COEF_W      = COEF_FRAC_BITS;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = COUNT_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FILTER_MODE = 3'd0,
      CSR_REGION_LEFT = 3'd1,
      CSR_REGION_TOP  = 3'd2,
      CSR_REGION_COLS = 3'd3,
      CSR_REGION_ROWS = 3'd4
   } csr_index_type;

   localparam logic MODE_SEPIA = 1'b0;
   localparam logic MODE_GRAY  = 1'b1;

   typedef struct packed {
      logic               filter_mode;
      logic [COORD_W-1:0] region_left;
      logic [COORD_W-1:0] region_top;
      logic [COUNT_W-1:0] region_cols;
      logic [COUNT_W-1:0] region_rows;
   } cfg_type;

   // thousandths to fixed point, round to nearest with ties up
   function automatic int unsigned fx_coef(input int unsigned k);
      return ((k << COEF_FRAC_BITS) + 500) / 1000;
   endfunction

   localparam logic [COEF_W-1:0] SEPIA_RR = COEF_W'(fx_coef(393));
   localparam logic [COEF_W-1:0] SEPIA_RG = COEF_W'(fx_coef(769));
   localparam logic [COEF_W-1:0] SEPIA_RB = COEF_W'(fx_coef(189));
   localparam logic [COEF_W-1:0] SEPIA_GR = COEF_W'(fx_coef(349));
   localparam logic [COEF_W-1:0] SEPIA_GG = COEF_W'(fx_coef(686));
   localparam logic [COEF_W-1:0] SEPIA_GB = COEF_W'(fx_coef(168));
   localparam logic [COEF_W-1:0] SEPIA_BR = COEF_W'(fx_coef(272));
   localparam logic [COEF_W-1:0] SEPIA_BG = COEF_W'(fx_coef(534));
   localparam logic [COEF_W-1:0] SEPIA_BB = COEF_W'(fx_coef(131));
   localparam logic [COEF_W-1:0] LUMA_R   = COEF_W'(fx_coef(299));
   localparam logic [COEF_W-1:0] LUMA_G   = COEF_W'(fx_coef(587));
   localparam logic [COEF_W-1:0] LUMA_B   = COEF_W'(fx_coef(114));

endpackage

`default_nettype wire

// ===== src/rsgf_csr.sv =====
// configuration registers: filter mode and filtered rectangle
// depends on rsgf_pkg
`timescale 1ns / 1ps
`default_nettype none

module rsgf_csr
   import rsgf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FILTER_MODE: cfg_in.filter_mode = csr_data[0];
            CSR_REGION_LEFT: cfg_in.region_left = csr_data[COORD_W-1:0];
            CSR_REGION_TOP:  cfg_in.region_top  = csr_data[COORD_W-1:0];
            CSR_REGION_COLS: cfg_in.region_cols = csr_data[COUNT_W-1:0];
            CSR_REGION_ROWS: cfg_in.region_rows = csr_data[COUNT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/rsgf_region.sv =====
// rectangle membership test for one pixel coordinate pair
// depends on rsgf_pkg
`timescale 1ns / 1ps
`default_nettype none

module rsgf_region
   import rsgf_pkg::*;
(
   input  wire cfg_type            cfg,
   input  wire logic [COORD_W-1:0] pixel_col,
   input  wire logic [COORD_W-1:0] pixel_row,
   output logic                    in_region
);

   localparam logic [COUNT_W-1:0] DIM_LIMIT = COUNT_W'(MAX_DIM);

   logic [COUNT_W-1:0] cols_lim;
   logic [COUNT_W-1:0] rows_lim;
   logic [COORD_W-1:0] col_off;
   logic [COORD_W-1:0] row_off;
   logic               col_ok;
   logic               row_ok;

   always_comb begin
      cols_lim  = (cfg.region_cols > DIM_LIMIT) ? DIM_LIMIT : cfg.region_cols;
      rows_lim  = (cfg.region_rows > DIM_LIMIT) ? DIM_LIMIT : cfg.region_rows;
      col_off   = pixel_col - cfg.region_left;
      row_off   = pixel_row - cfg.region_top;
      col_ok    = (pixel_col >= cfg.region_left) && ({1'b0, col_off} < cols_lim);
      row_ok    = (pixel_row >= cfg.region_top) && ({1'b0, row_off} < rows_lim);
      in_region = col_ok && row_ok;
   end

endmodule

`default_nettype wire

// ===== src/rsgf_mac3.sv =====
// one output channel: three coefficient products, sum, shift and saturate
// depends on rsgf_pkg
`timescale 1ns / 1ps
`default_nettype none

module rsgf_mac3
   import rsgf_pkg::*;
(
   input  wire logic [CHAN_W-1:0] red,
   input  wire logic [CHAN_W-1:0] green,
   input  wire logic [CHAN_W-1:0] blue,
   input  wire logic [COEF_W-1:0] coef_r,
   input  wire logic [COEF_W-1:0] coef_g,
   input  wire logic [COEF_W-1:0] coef_b,
   output logic      [CHAN_W-1:0] result
);

   localparam int SUM_W = CHAN_W + COEF_W + 2;
   localparam logic [SUM_W-1:0] CHAN_MAX = SUM_W'((1 << CHAN_W) - 1);

   logic [SUM_W-1:0] prod_r;
   logic [SUM_W-1:0] prod_g;
   logic [SUM_W-1:0] prod_b;
   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] scaled;

   always_comb begin
      prod_r = SUM_W'(red)   * SUM_W'(coef_r);
      prod_g = SUM_W'(green) * SUM_W'(coef_g);
      prod_b = SUM_W'(blue)  * SUM_W'(coef_b);
      sum    = prod_r + prod_g + prod_b;
      scaled = sum >> COEF_FRAC_BITS;
      result = (scaled > CHAN_MAX) ? CHAN_MAX[CHAN_W-1:0] : scaled[CHAN_W-1:0];
   end

endmodule

`default_nettype wire

// ===== src/region_sepia_gray_filter_core.sv =====
// region sepia / grayscale filter top level, uses rsgf_pkg, rsgf_csr, rsgf_region, rsgf_mac3
// a request passes the input register and then the result register, which drives the rsp outputs
// throughput: one request per cycle, set by the input register feeding the result register, except
// that stalls on the result side back up through both registers with no bubble
// reset (synchronous): pipeline empties, all configuration registers clear to zero
`timescale 1ns / 1ps
`default_nettype none

module region_sepia_gray_filter_core
   import rsgf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [CHAN_W-1:0]      req_in_red,
   input  wire logic [CHAN_W-1:0]      req_in_green,
   input  wire logic [CHAN_W-1:0]      req_in_blue,
   input  wire logic [COORD_W-1:0]     req_pixel_col,
   input  wire logic [COORD_W-1:0]     req_pixel_row,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [CHAN_W-1:0]      rsp_out_red,
   output logic      [CHAN_W-1:0]      rsp_out_green,
   output logic      [CHAN_W-1:0]      rsp_out_blue,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg;

   logic               s1_valid_ff;
   logic [CHAN_W-1:0]  s1_red_ff;
   logic [CHAN_W-1:0]  s1_green_ff;
   logic [CHAN_W-1:0]  s1_blue_ff;
   logic [COORD_W-1:0] s1_col_ff;
   logic [COORD_W-1:0] s1_row_ff;

   logic               rsp_valid_ff;
   logic               rsp_gray_ff;
   logic [CHAN_W-1:0]  rsp_red_ff;
   logic [CHAN_W-1:0]  rsp_green_ff;
   logic [CHAN_W-1:0]  rsp_blue_ff;

   logic               rsp_gray_in;
   logic [CHAN_W-1:0]  rsp_red_in;
   logic [CHAN_W-1:0]  rsp_green_in;
   logic [CHAN_W-1:0]  rsp_blue_in;

   logic               out_ready;
   logic               s1_ready;
   logic               in_region;
   logic [CHAN_W-1:0]  sepia_r;
   logic [CHAN_W-1:0]  sepia_g;
   logic [CHAN_W-1:0]  sepia_b;
   logic [CHAN_W-1:0]  luma;

   rsgf_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   rsgf_region u_region (
      .cfg       (cfg),
      .pixel_col (s1_col_ff),
      .pixel_row (s1_row_ff),
      .in_region (in_region)
   );

   rsgf_mac3 u_sepia_r (
      .red (s1_red_ff), .green (s1_green_ff), .blue (s1_blue_ff),
      .coef_r (SEPIA_RR), .coef_g (SEPIA_RG), .coef_b (SEPIA_RB),
      .result (sepia_r)
   );

   rsgf_mac3 u_sepia_g (
      .red (s1_red_ff), .green (s1_green_ff), .blue (s1_blue_ff),
      .coef_r (SEPIA_GR), .coef_g (SEPIA_GG), .coef_b (SEPIA_GB),
      .result (sepia_g)
   );

   rsgf_mac3 u_sepia_b (
      .red (s1_red_ff), .green (s1_green_ff), .blue (s1_blue_ff),
      .coef_r (SEPIA_BR), .coef_g (SEPIA_BG), .coef_b (SEPIA_BB),
      .result (sepia_b)
   );

   rsgf_mac3 u_luma (
      .red (s1_red_ff), .green (s1_green_ff), .blue (s1_blue_ff),
      .coef_r (LUMA_R), .coef_g (LUMA_G), .coef_b (LUMA_B),
      .result (luma)
   );

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign req_stall = !s1_ready;

   always_comb begin
      rsp_gray_in  = in_region && (cfg.filter_mode == MODE_GRAY);
      rsp_red_in   = s1_red_ff;
      rsp_green_in = s1_green_ff;
      rsp_blue_in  = s1_blue_ff;
      if (in_region) begin
         if (cfg.filter_mode == MODE_GRAY) begin
            rsp_red_in   = luma;
            rsp_green_in = luma;
            rsp_blue_in  = luma;
         end else begin
            rsp_red_in   = sepia_r;
            rsp_green_in = sepia_g;
            rsp_blue_in  = sepia_b;
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_red_ff   <= req_in_red;
         s1_green_ff <= req_in_green;
         s1_blue_ff  <= req_in_blue;
         s1_col_ff   <= req_pixel_col;
         s1_row_ff   <= req_pixel_row;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s1_valid_ff) begin
         rsp_gray_ff  <= rsp_gray_in;
         rsp_red_ff   <= rsp_red_in;
         rsp_green_ff <= rsp_green_in;
         rsp_blue_ff  <= rsp_blue_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_red_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_blue  = rsp_blue_ff;

`ifndef NO_ASSERTIONS
   a_req_enters_s1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted request did not reach the input register");

   a_s1_reaches_rsp: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_ready) |=> rsp_valid_ff)
      else $error("input register moved on but no result was offered");

   a_gray_equal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_gray_ff) |->
         (rsp_red_ff == rsp_green_ff) && (rsp_green_ff == rsp_blue_ff))
      else $error("grayscale result with unequal channels");
`endif

endmodule

`default_nettype wire
